FILE: rtl/kdq_pkg.sv
// Keyword detection qualifier: shared types and constants.
// Used by every module of the block; depends on nothing.
package kdq_pkg;

   localparam int unsigned ClassWidth = 4;
   localparam int unsigned ProbWidth  = 16;
   localparam int unsigned PctWidth   = 7;
   localparam int unsigned CountWidth = 8;

   localparam int unsigned PctScale = 100;
   localparam int unsigned PctRound = 16384;
   localparam int unsigned PctMax   = 100;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_FINISH,
      ST_CONFIRM,
      ST_EMIT
   } kdq_state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic eval;
      logic finish;
      logic confirm;
      logic emit;
   } kdq_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic go_divide;
      logic div_done;
      logic slot_free;
   } kdq_status_type;

endpackage

FILE: rtl/kdq_div.sv
// Keyword detection qualifier: serial restoring divider, one quotient bit a cycle.
// Unsigned magnitude divide of the mean update step; depends on kdq_pkg.
module kdq_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [kdq_pkg::ProbWidth-1:0]       dividend,
   input  logic [kdq_pkg::CountWidth-1:0]      divisor,
   output logic                                done,
   output logic [kdq_pkg::ProbWidth-1:0]       quotient
);

   localparam int unsigned QW = kdq_pkg::ProbWidth;
   localparam int unsigned DW = kdq_pkg::CountWidth;
   localparam int unsigned CW = $clog2(QW);

   logic [QW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [DW:0]   shifted;
   logic [DW+1:0] trial;
   logic          last;

   assign shifted = {rem_ff, quo_ff[QW-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dsr_ff};
   assign last    = (cnt_ff == CW'(QW - 1));

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // borrow clear: divisor fits, take the bit
         if (!trial[DW+1]) begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/kdq_ctrl.sv
// Keyword detection qualifier: sequencing state machine.
// Drives datapath commands from its status; depends on kdq_pkg.
module kdq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  kdq_pkg::kdq_status_type status,
   output kdq_pkg::kdq_cmd_type    cmd
);

   kdq_pkg::kdq_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kdq_pkg::ST_IDLE: begin
            if (req_valid) state_in = kdq_pkg::ST_EVAL;
         end
         kdq_pkg::ST_EVAL: begin
            state_in = status.go_divide ? kdq_pkg::ST_DIV : kdq_pkg::ST_EMIT;
         end
         kdq_pkg::ST_DIV: begin
            if (status.div_done) state_in = kdq_pkg::ST_FINISH;
         end
         kdq_pkg::ST_FINISH: begin
            state_in = kdq_pkg::ST_CONFIRM;
         end
         kdq_pkg::ST_CONFIRM: begin
            state_in = kdq_pkg::ST_EMIT;
         end
         kdq_pkg::ST_EMIT: begin
            if (status.slot_free) state_in = kdq_pkg::ST_IDLE;
         end
         default: begin
            state_in = kdq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      case (state_ff)
         kdq_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         kdq_pkg::ST_EVAL:    cmd.eval    = 1'b1;
         kdq_pkg::ST_DIV:     cmd         = '0;
         kdq_pkg::ST_FINISH:  cmd.finish  = 1'b1;
         kdq_pkg::ST_CONFIRM: cmd.confirm = 1'b1;
         kdq_pkg::ST_EMIT:    cmd.emit    = status.slot_free;
         default:             cmd         = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kdq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/kdq_datapath.sv
// Keyword detection qualifier: verdict registers, tracking state, mean update, result beat.
// Instantiates kdq_div; depends on kdq_pkg.
module kdq_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  kdq_pkg::kdq_cmd_type              cmd,
   output kdq_pkg::kdq_status_type           status,
   input  logic                              req_kind,
   input  logic [kdq_pkg::ClassWidth-1:0]    req_class_id,
   input  logic [kdq_pkg::ProbWidth-1:0]     req_probability,
   input  logic [kdq_pkg::PctWidth-1:0]      req_threshold_pct,
   input  logic [kdq_pkg::CountWidth-1:0]    req_count_needed,
   input  logic                              req_is_command,
   input  logic                              req_is_actionable,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_detected,
   output logic [kdq_pkg::ClassWidth-1:0]    rsp_keyword_class,
   output logic [kdq_pkg::PctWidth-1:0]      rsp_avg_percent
);

   localparam int unsigned CLW = kdq_pkg::ClassWidth;
   localparam int unsigned PW  = kdq_pkg::ProbWidth;
   localparam int unsigned TW  = kdq_pkg::PctWidth;
   localparam int unsigned NW  = kdq_pkg::CountWidth;
   localparam int unsigned MW  = PW + TW;   // prob * 100 fits here

   // captured verdict
   logic           kind_ff, cmd_ff, act_ff;
   logic [CLW-1:0] cls_ff;
   logic [PW-1:0]  prob_ff;
   logic [TW-1:0]  thr_ff;
   logic [NW-1:0]  need_ff;

   // tracking state
   logic           waiting_ff, waiting_in;
   logic [CLW-1:0] blocked_ff, blocked_in;
   logic           av_ff, av_in;
   logic [CLW-1:0] aclass_ff, aclass_in;
   logic [NW-1:0]  hit_ff, hit_in;
   logic [PW-1:0]  mean_ff, mean_in;
   logic [CLW-1:0] mclass_ff, mclass_in;
   logic [NW-1:0]  mcnt_ff, mcnt_in;
   logic           neg_ff, neg_in;

   // pending result and output register
   logic           rdet_ff, rdet_in;
   logic [CLW-1:0] rcls_ff, rcls_in;
   logic [TW-1:0]  rpct_ff, rpct_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_det_ff;
   logic [CLW-1:0] rsp_cls_ff;
   logic [TW-1:0]  rsp_pct_ff;

   logic [MW-1:0]  prob_x100, thr_lim;
   logic           pass, blocked_hit, go_divide, is_new;
   logic [PW-1:0]  mean_eff;
   logic [NW-1:0]  hit_eff, hit_inc;
   logic [PW:0]    diff, diff_abs;
   logic           miss_restart, miss_clear;
   logic [NW-1:0]  miss_base, miss_inc;
   logic           div_done;
   logic [PW-1:0]  quo;
   logic [PW:0]    step;
   logic [PW+1:0]  sum;
   logic [MW-1:0]  pct_full;
   logic [MW-PW:0] pct_raw;
   logic [TW-1:0]  pct;

   assign prob_x100   = MW'(prob_ff) * MW'(kdq_pkg::PctScale);
   assign thr_lim     = MW'({thr_ff, {PW-1{1'b0}}});
   assign pass        = cmd_ff && ((thr_ff == '0) || (prob_x100 >= thr_lim));
   assign blocked_hit = waiting_ff && (cls_ff == blocked_ff);
   assign go_divide   = !kind_ff && !blocked_hit && pass;

   // a new hit run starts from an empty mean
   assign is_new   = !av_ff || (cls_ff != aclass_ff);
   assign mean_eff = is_new ? '0 : mean_ff;
   assign hit_eff  = is_new ? '0 : hit_ff;
   assign hit_inc  = (hit_eff == '1) ? hit_eff : hit_eff + 1'b1;
   assign diff     = {1'b0, prob_ff} - {1'b0, mean_eff};
   assign diff_abs = diff[PW] ? (~diff + 1'b1) : diff;

   assign miss_restart = (mcnt_ff == '0) || (mclass_ff != cls_ff);
   assign miss_base    = miss_restart ? '0 : mcnt_ff;
   assign miss_inc     = (miss_base == '1) ? miss_base : miss_base + 1'b1;
   assign miss_clear   = (miss_inc >= need_ff);

   kdq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.eval && go_divide),
      .dividend (diff_abs[PW-1:0]),
      .divisor  (hit_inc),
      .done     (div_done),
      .quotient (quo)
   );

   // truncating signed step, then clamp to the unsigned mean range
   assign step = neg_ff ? (~{1'b0, quo} + 1'b1) : {1'b0, quo};
   assign sum  = {2'b00, mean_ff} + {step[PW], step};

   assign pct_full = MW'(mean_ff) * MW'(kdq_pkg::PctScale) + MW'(kdq_pkg::PctRound);
   assign pct_raw  = pct_full[MW-1:PW-1];
   assign pct      = (pct_raw > (MW-PW+1)'(kdq_pkg::PctMax)) ? TW'(kdq_pkg::PctMax)
                                                              : pct_raw[TW-1:0];

   always_comb begin
      waiting_in = waiting_ff;
      blocked_in = blocked_ff;
      av_in      = av_ff;
      aclass_in  = aclass_ff;
      hit_in     = hit_ff;
      mean_in    = mean_ff;
      mclass_in  = mclass_ff;
      mcnt_in    = mcnt_ff;
      neg_in     = neg_ff;
      rdet_in    = rdet_ff;
      rcls_in    = rcls_ff;
      rpct_in    = rpct_ff;

      if (cmd.eval) begin
         rdet_in = 1'b0;
         rcls_in = '0;
         rpct_in = '0;
         if (kind_ff) begin
            waiting_in = 1'b0;
            blocked_in = '0;
            av_in      = 1'b0;
            aclass_in  = '0;
            hit_in     = '0;
            mean_in    = '0;
            mclass_in  = '0;
            mcnt_in    = '0;
         end else if (!blocked_hit) begin
            waiting_in = 1'b0;
            if (!pass) begin
               if (cmd_ff) begin
                  av_in   = 1'b0;
                  hit_in  = '0;
                  mean_in = '0;
               end
               mclass_in = miss_restart ? cls_ff : mclass_ff;
               mcnt_in   = miss_inc;
               if (miss_clear) begin
                  av_in     = 1'b0;
                  hit_in    = '0;
                  mean_in   = '0;
                  mclass_in = '0;
                  mcnt_in   = '0;
               end
            end else begin
               mcnt_in = '0;
               if (is_new) begin
                  av_in     = 1'b1;
                  aclass_in = cls_ff;
                  mclass_in = '0;
               end
               hit_in  = hit_inc;
               mean_in = mean_eff;
               neg_in  = diff[PW];
            end
         end
      end

      if (cmd.finish) begin
         if (sum[PW+1]) begin
            mean_in = '0;
         end else if (sum[PW]) begin
            mean_in = '1;
         end else begin
            mean_in = sum[PW-1:0];
         end
      end

      if (cmd.confirm && (hit_ff >= need_ff)) begin
         av_in      = 1'b0;
         hit_in     = '0;
         mean_in    = '0;
         mclass_in  = '0;
         mcnt_in    = '0;
         waiting_in = 1'b1;
         blocked_in = cls_ff;
         if (act_ff) begin
            rdet_in    = 1'b1;
            rcls_in    = cls_ff;
            rpct_in    = pct;
            waiting_in = 1'b0;
            blocked_in = '0;
            aclass_in  = '0;
         end
      end
   end

   assign status.go_divide = go_divide;
   assign status.div_done  = div_done;
   assign status.slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff   <= 1'b0;
         blocked_ff   <= '0;
         av_ff        <= 1'b0;
         aclass_ff    <= '0;
         hit_ff       <= '0;
         mean_ff      <= '0;
         mclass_ff    <= '0;
         mcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         waiting_ff   <= waiting_in;
         blocked_ff   <= blocked_in;
         av_ff        <= av_in;
         aclass_ff    <= aclass_in;
         hit_ff       <= hit_in;
         mean_ff      <= mean_in;
         mclass_ff    <= mclass_in;
         mcnt_ff      <= mcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff  <= neg_in;
      rdet_ff <= rdet_in;
      rcls_ff <= rcls_in;
      rpct_ff <= rpct_in;
      if (cmd.capture) begin
         kind_ff <= req_kind;
         cls_ff  <= req_class_id;
         prob_ff <= req_probability;
         thr_ff  <= req_threshold_pct;
         need_ff <= req_count_needed;
         cmd_ff  <= req_is_command;
         act_ff  <= req_is_actionable;
      end
      if (cmd.emit) begin
         rsp_det_ff <= rdet_ff;
         rsp_cls_ff <= rcls_ff;
         rsp_pct_ff <= rpct_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_detected      = rsp_det_ff;
   assign rsp_keyword_class = rsp_cls_ff;
   assign rsp_avg_percent   = rsp_pct_ff;

endmodule

FILE: rtl/keyword_detection_qualifier.sv
// Keyword detection qualifier, top level: controller plus datapath.
// Depends on kdq_pkg, kdq_ctrl, kdq_datapath (which holds kdq_div).
//
// Usage:
//   req_* carries one classifier verdict per beat (kind 1 clears all state);
//   rsp_* returns exactly one result beat per verdict, in order.
//   Both channels are valid/ready; a beat moves when both are high.
// Sequencing:
//   One verdict is in flight at a time. A verdict that is not a hit
//   goes from evaluation straight to its result beat; a hit also runs
//   the serial divider of the mean update, then finishes the mean and
//   confirms. A new verdict can be accepted in the cycle after its
//   result beat is loaded.
// Reset:
//   Synchronous, active high; all detection state returns to zero and no
//   result beat is pending.
// Stall:
//   The result waits in the output register while rsp_ready is low; the
//   next verdict is accepted and worked on, and holds at the result step
//   until the output register frees up.
module keyword_detection_qualifier (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  logic [kdq_pkg::ClassWidth-1:0]    req_class_id,
   input  logic [kdq_pkg::ProbWidth-1:0]     req_probability,
   input  logic [kdq_pkg::PctWidth-1:0]      req_threshold_pct,
   input  logic [kdq_pkg::CountWidth-1:0]    req_count_needed,
   input  logic                              req_is_command,
   input  logic                              req_is_actionable,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_detected,
   output logic [kdq_pkg::ClassWidth-1:0]    rsp_keyword_class,
   output logic [kdq_pkg::PctWidth-1:0]      rsp_avg_percent
);

   kdq_pkg::kdq_cmd_type    cmd;
   kdq_pkg::kdq_status_type status;

   kdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   kdq_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_kind),
      .req_class_id      (req_class_id),
      .req_probability   (req_probability),
      .req_threshold_pct (req_threshold_pct),
      .req_count_needed  (req_count_needed),
      .req_is_command    (req_is_command),
      .req_is_actionable (req_is_actionable),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_detected      (rsp_detected),
      .rsp_keyword_class (rsp_keyword_class),
      .rsp_avg_percent   (rsp_avg_percent)
   );

   // one verdict at a time: no accept right after an accept
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("verdict accepted while another is in flight");

   // a result beat is only loaded once the previous one has left
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_avg_percent <= 7'(kdq_pkg::PctMax)))
      else $error("reported percent above cap");

   a_quiet_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_detected) |-> (rsp_keyword_class == '0 && rsp_avg_percent == '0))
      else $error("non-detection result carries class or percent");

endmodule

FILE: tb/keyword_detection_qualifier_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for keyword_detection_qualifier: directed table, then random verdicts.
// Depends on kdq_pkg and the keyword_detection_qualifier RTL; carries its own detection predictor.
module keyword_detection_qualifier_test;

   localparam int ClockPeriod   = 12;
   localparam int NumRandom     = 1000;
   localparam int NumDirected   = 24;
   localparam int CycleLimit    = 200000;
   localparam int TailCycles    = 30;
   localparam int HoldoffCycles = 400;
   localparam int MaxReports    = 10;

   typedef logic [kdq_pkg::ClassWidth-1:0] cls_type;
   typedef logic [kdq_pkg::ProbWidth-1:0]  prob_type;
   typedef logic [kdq_pkg::PctWidth-1:0]   pct_type;
   typedef logic [kdq_pkg::CountWidth-1:0] count_type;

   typedef struct packed {
      logic      kind;
      cls_type   class_id;
      prob_type  probability;
      pct_type   threshold_pct;
      count_type count_needed;
      logic      is_command;
      logic      is_actionable;
   } verdict_type;

   typedef struct packed {
      logic    detected;
      cls_type keyword_class;
      pct_type avg_percent;
   } detection_type;

   logic      clock;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   logic      req_kind = 1'b0;
   cls_type   req_class_id = '0;
   prob_type  req_probability = '0;
   pct_type   req_threshold_pct = '0;
   count_type req_count_needed = '0;
   logic      req_is_command = 1'b0;
   logic      req_is_actionable = 1'b0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   logic      rsp_detected;
   cls_type   rsp_keyword_class;
   pct_type   rsp_avg_percent;

   // predictor state
   bit        blk_waiting = 1'b0;
   cls_type   blk_class = '0;
   bit        trk_valid = 1'b0;
   cls_type   trk_class = '0;
   count_type trk_hits = '0;
   prob_type  trk_mean = '0;
   cls_type   miss_cls = '0;
   count_type miss_cnt = '0;

   detection_type detection_queue[$];
   int            error_count = 0;
   int            results_seen = 0;
   int            cycle_count = 0;
   int            sender_idle_pct = 9;
   int            receiver_idle_pct = 54;
   bit            holdoff_go = 1'b0;
   bit            holdoff_active = 1'b0;
   detection_type got;
   detection_type want;

   // kind, class, prob, thr, need, cmd, act | typed?, detected, class, pct
   int unsigned directed_tab [NumDirected][11] = '{
      '{1,  0,     0,   0,   0, 0, 0,  1, 0,  0,   0},  // clear right after reset
      '{0,  3, 32768, 100,   1, 1, 1,  1, 1,  3, 100},  // full scale meets 100%
      '{0, 15, 65535,   0,   0, 1, 1,  1, 1, 15, 100},  // over-range prob, need 0, capped
      '{0,  0,     0,   0,   0, 1, 1,  1, 1,  0,   0},  // zero threshold always passes
      '{0,  5, 40000,  10,   0, 0, 1,  1, 0,  0,   0},  // non-command miss
      '{0,  7, 20000,   0,   1, 1, 0,  1, 0,  0,   0},  // silent confirm blocks class 7
      '{0,  7, 32768,   0,   1, 1, 1,  1, 0,  0,   0},  // blocked class ignored
      '{0,  8, 16384,  50,   2, 1, 1,  1, 0,  0,   0},  // threshold met exactly
      '{0,  8, 32768,  50,   2, 1, 1,  0, 0,  0,   0},
      '{0,  2, 32767, 100,   3, 1, 1,  1, 0,  0,   0},  // one LSB under threshold
      '{0,  4, 30000,  10,   3, 1, 1,  1, 0,  0,   0},
      '{0,  4, 10001,  10,   3, 1, 1,  0, 0,  0,   0},  // negative step truncates toward zero
      '{0,  4,  5000,  10,   3, 1, 1,  0, 0,  0,   0},
      '{0,  9, 20000,  30,   2, 1, 1,  0, 0,  0,   0},
      '{0,  9,  1000,  30,   2, 1, 1,  0, 0,  0,   0},  // command miss drops hits
      '{0,  9, 20000,  30,   2, 1, 1,  0, 0,  0,   0},
      '{0,  9, 20000,  30,   2, 1, 1,  0, 0,  0,   0},
      '{0,  1, 65535, 127, 255, 1, 1,  0, 0,  0,   0},
      '{1, 15, 65535, 127, 255, 1, 1,  1, 0,  0,   0},  // clear with every field set
      '{0,  6,     0,   0,   2, 0, 0,  1, 0,  0,   0},
      '{0,  6,     0,   0,   2, 0, 0,  1, 0,  0,   0},  // misses reach need, tracking clears
      '{0, 12,   327,   1,   1, 1, 1,  1, 0,  0,   0},
      '{0, 12,   328,   1,   1, 1, 1,  0, 0,  0,   0},
      '{0, 12, 32768,   0,   0, 1, 0,  1, 0,  0,   0}
   };

   keyword_detection_qualifier u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_class_id      (req_class_id),
      .req_probability   (req_probability),
      .req_threshold_pct (req_threshold_pct),
      .req_count_needed  (req_count_needed),
      .req_is_command    (req_is_command),
      .req_is_actionable (req_is_actionable),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_detected      (rsp_detected),
      .rsp_keyword_class (rsp_keyword_class),
      .rsp_avg_percent   (rsp_avg_percent)
   );

   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   function automatic void clear_tracking();
      trk_valid = 1'b0;
      trk_hits  = '0;
      trk_mean  = '0;
      miss_cls  = '0;
      miss_cnt  = '0;
   endfunction

   function automatic void clear_all();
      clear_tracking();
      blk_waiting = 1'b0;
      blk_class   = '0;
      trk_class   = '0;
   endfunction

   task automatic qualify_verdict(input verdict_type v, output detection_type r);
      bit          hit;
      int          prob_i;
      int          mean_i;
      int          hits_i;
      int          m;
      int unsigned pct;
      int unsigned mean_snap;
      int unsigned prob_u;
      int unsigned thr_u;
      r      = '0;
      prob_u = 32'(v.probability);
      thr_u  = 32'(v.threshold_pct);
      if (v.kind) begin
         clear_all();
         return;
      end
      hit = v.is_command && (thr_u == 0 || prob_u * kdq_pkg::PctScale >= (thr_u << 15));
      if (blk_waiting) begin
         if (v.class_id == blk_class)
            return;
         blk_waiting = 1'b0;
      end
      if (!hit) begin
         if (v.is_command) begin
            trk_valid = 1'b0;
            trk_hits  = '0;
            trk_mean  = '0;
         end
         if (miss_cnt == 0 || miss_cls != v.class_id) begin
            miss_cls = v.class_id;
            miss_cnt = '0;
         end
         if (miss_cnt != '1)
            miss_cnt = miss_cnt + 1'b1;
         if (miss_cnt >= v.count_needed)
            clear_tracking();
         return;
      end
      miss_cnt = '0;
      if (!trk_valid || v.class_id != trk_class) begin
         clear_tracking();
         trk_valid = 1'b1;
         trk_class = v.class_id;
      end
      if (trk_hits != '1)
         trk_hits = trk_hits + 1'b1;
      prob_i = int'(v.probability);
      mean_i = int'(trk_mean);
      hits_i = int'(trk_hits);
      // signed int division truncates toward zero
      m = mean_i + (prob_i - mean_i) / hits_i;
      if (m < 0)
         m = 0;
      if (m > 65535)
         m = 65535;
      trk_mean = m[kdq_pkg::ProbWidth-1:0];
      if (trk_hits < v.count_needed)
         return;
      mean_snap = 32'(trk_mean);
      clear_tracking();
      blk_waiting = 1'b1;
      blk_class   = v.class_id;
      if (v.is_actionable) begin
         pct = (mean_snap * kdq_pkg::PctScale + kdq_pkg::PctRound) >> 15;
         if (pct > kdq_pkg::PctMax)
            pct = kdq_pkg::PctMax;
         r.detected      = 1'b1;
         r.keyword_class = v.class_id;
         r.avg_percent   = pct[kdq_pkg::PctWidth-1:0];
         clear_all();
      end
   endtask

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_verdict(input verdict_type v, input bit typed,
                               input detection_type typed_result);
      detection_type predicted;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_kind          = v.kind;
      req_class_id      = v.class_id;
      req_probability   = v.probability;
      req_threshold_pct = v.threshold_pct;
      req_count_needed  = v.count_needed;
      req_is_command    = v.is_command;
      req_is_actionable = v.is_actionable;
      req_valid         = 1'b1;
      do
         @(posedge clock);
      while (!req_ready);
      qualify_verdict(v, predicted);
      detection_queue.push_back(typed ? typed_result : predicted);
      @(negedge clock);
   endtask

   always @(negedge clock)
      rsp_ready <= !holdoff_active && ($urandom_range(0, 99) >= receiver_idle_pct);

   // long receiver stall so the block backs up into the request side
   initial begin
      wait (holdoff_go);
      repeat (20) @(posedge clock);
      holdoff_active = 1'b1;
      repeat (HoldoffCycles) @(posedge clock);
      holdoff_active = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got.detected      = rsp_detected;
         got.keyword_class = rsp_keyword_class;
         got.avg_percent   = rsp_avg_percent;
         if (detection_queue.size() == 0) begin
            if (error_count < MaxReports)
               $display("%0t: result beat %0d with no verdict outstanding: %s%0d %s%0d %s%0d",
                        $realtime, results_seen, "det=", got.detected,
                        "class=", got.keyword_class, "pct=", got.avg_percent);
            error_count++;
         end else begin
            want = detection_queue.pop_front();
            if (got.detected !== want.detected || got.keyword_class !== want.keyword_class ||
                got.avg_percent !== want.avg_percent) begin
               if (error_count < MaxReports)
                  $display("%0t: result %0d: expected det=%0d class=%0d pct=%0d, %s%0d %s%0d %s%0d",
                           $realtime, results_seen, want.detected, want.keyword_class,
                           want.avg_percent, "got det=", got.detected,
                           "class=", got.keyword_class, "pct=", got.avg_percent);
               error_count++;
            end
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  detection_queue.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      verdict_type   v;
      detection_type typed_result;
      logic [63:0]   noise;
      int unsigned   sel;
      int unsigned   kw_minp;
      int            kw_left;
      cls_type       kw_cls;
      pct_type       kw_thr;
      count_type     kw_need;
      logic          kw_cmd;
      logic          kw_act;
      kw_left = 0;
      kw_cls  = '0;
      kw_thr  = '0;
      kw_need = '0;
      kw_cmd  = 1'b1;
      kw_act  = 1'b1;
      kw_minp = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int k = 0; k < NumDirected; k++) begin
         v.kind                     = directed_tab[k][0][0];
         v.class_id                 = directed_tab[k][1][kdq_pkg::ClassWidth-1:0];
         v.probability              = directed_tab[k][2][kdq_pkg::ProbWidth-1:0];
         v.threshold_pct            = directed_tab[k][3][kdq_pkg::PctWidth-1:0];
         v.count_needed             = directed_tab[k][4][kdq_pkg::CountWidth-1:0];
         v.is_command               = directed_tab[k][5][0];
         v.is_actionable            = directed_tab[k][6][0];
         typed_result.detected      = directed_tab[k][8][0];
         typed_result.keyword_class = directed_tab[k][9][kdq_pkg::ClassWidth-1:0];
         typed_result.avg_percent   = directed_tab[k][10][kdq_pkg::PctWidth-1:0];
         send_verdict(v, directed_tab[k][7] != 0, typed_result);
      end

      for (int i = 0; i < NumRandom; i++) begin
         if (i == 0) begin
            holdoff_go = 1'b1;
         end else if (i == NumRandom / 3) begin
            sender_idle_pct   = 54;
            receiver_idle_pct = 9;
         end else if (i == 2 * NumRandom / 3) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         noise = {$urandom, $urandom};
         v     = noise[$bits(verdict_type)-1:0];
         sel   = $urandom_range(0, 99);
         if (sel < 4) begin
            v.kind = 1'b1;
         end else if (sel < 16) begin
            v.kind = 1'b0;
         end else begin
            // keyword bursts: one class with steady settings, mostly hits
            if (kw_left == 0) begin
               if ($urandom_range(0, 4) != 0)
                  kw_cls = cls_type'($urandom);
               sel = $urandom_range(0, 99);
               if (sel < 10)
                  kw_need = '0;
               else if (sel < 80)
                  kw_need = count_type'($urandom_range(1, 4));
               else if (sel < 95)
                  kw_need = count_type'($urandom_range(5, 12));
               else
                  kw_need = count_type'($urandom_range(0, 255));
               sel = $urandom_range(0, 99);
               if (sel < 20)
                  kw_thr = '0;
               else if (sel < 90)
                  kw_thr = pct_type'($urandom_range(1, 100));
               else
                  kw_thr = pct_type'($urandom_range(101, 127));
               kw_act  = ($urandom_range(0, 3) != 0);
               kw_cmd  = ($urandom_range(0, 9) != 0);
               kw_left = (kw_need == 0) ? 1 : ((kw_need > 16) ? 16 : int'(kw_need));
               kw_left += int'($urandom_range(0, 2));
               kw_minp = (int'(kw_thr) * 32768 + 99) / 100;
            end
            kw_left--;
            v.kind          = 1'b0;
            v.class_id      = kw_cls;
            v.threshold_pct = kw_thr;
            v.count_needed  = kw_need;
            v.is_command    = kw_cmd;
            v.is_actionable = kw_act;
            sel = $urandom_range(0, 99);
            if (sel < 6) begin
               v.class_id    = cls_type'($urandom);
               v.probability = prob_type'($urandom_range(0, 32768));
            end else if (sel < 18) begin
               if (kw_minp > 0) begin
                  v.probability = prob_type'($urandom_range(0, kw_minp - 1));
               end else begin
                  v.probability = prob_type'($urandom_range(0, 32768));
                  v.is_command  = 1'b0;
               end
            end else if (sel < 26 || kw_minp > 32768) begin
               v.probability = prob_type'($urandom_range(kw_minp, 65535));
            end else begin
               v.probability = prob_type'($urandom_range(kw_minp, 32768));
            end
         end
         send_verdict(v, 1'b0, '0);
      end
      req_valid = 1'b0;

      while (detection_queue.size() != 0)
         @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
rtl/kdq_pkg.sv
rtl/kdq_div.sv
rtl/kdq_ctrl.sv
rtl/kdq_datapath.sv
rtl/keyword_detection_qualifier.sv
tb/keyword_detection_qualifier_test.sv
